### rtl/isa_pkg.sv
// Shared types, codes and widths for the indexed shift array.
package isa_pkg;

    localparam int DEFAULT_CAPACITY     = 64;
    localparam int DEFAULT_ELEMENT_BITS = 32;

    localparam int KIND_BITS   = 3;
    localparam int POS_BITS    = 7;
    localparam int VALUE_BITS  = 32;
    localparam int FOUND_BITS  = 6;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;

    localparam int GROUP      = 8;
    localparam int GROUP_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_WRITE  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_SEARCH = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_MISSING = 2'd2;

    localparam logic [2:0] CMD_IDLE   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_SEARCH = 3'd5;
    localparam logic [2:0] CMD_SHIFT  = 3'd6;

    typedef struct packed {
        logic [2:0]          code;
        logic [POS_BITS-1:0] pos;
    } cell_cmd_t;

    typedef struct packed {
        logic                  busy;
        logic                  shift;
        logic                  done;
        logic                  hit;
        logic                  srch;
        logic [FOUND_BITS-1:0] found;
    } scan_res_t;

endpackage

### rtl/isa_cell.sv
// One storage cell of the shift array: entry, neighbor shift and scan tag.
module isa_cell #(
    parameter int ELEMENT_BITS = isa_pkg::DEFAULT_ELEMENT_BITS,
    parameter int CAPACITY     = isa_pkg::DEFAULT_CAPACITY,
    parameter int INDEX        = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  isa_pkg::cell_cmd_t                   cmd,
    input  logic [ELEMENT_BITS-1:0]              cmd_val,
    input  logic [$clog2(CAPACITY+1)-1:0]        count,
    input  logic [ELEMENT_BITS-1:0]              left_val,
    input  logic [ELEMENT_BITS-1:0]              right_val,
    input  logic                                 tag_in_hit,
    input  logic [ELEMENT_BITS-1:0]              tag_in_val,
    output logic [ELEMENT_BITS-1:0]              entry_val,
    output logic                                 tag_hit,
    output logic [ELEMENT_BITS-1:0]              tag_val
);

    localparam int CW   = $clog2(CAPACITY+1);
    localparam int CMPW = (CW > isa_pkg::POS_BITS) ? CW : isa_pkg::POS_BITS;
    localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

    logic [ELEMENT_BITS-1:0] entry_reg, entry_next;
    logic                    tag_hit_reg, tag_hit_next;
    logic [ELEMENT_BITS-1:0] tag_val_reg, tag_val_next;
    logic [CMPW-1:0]         pos_w, cnt_w;

    always_comb begin
        pos_w        = CMPW'(cmd.pos);
        cnt_w        = CMPW'(count);
        entry_next   = entry_reg;
        tag_hit_next = tag_hit_reg;
        tag_val_next = tag_val_reg;
        unique case (cmd.code)
            isa_pkg::CMD_INSERT: begin
                if (IDX > pos_w) begin
                    entry_next = left_val;
                end else if (IDX == pos_w) begin
                    entry_next = cmd_val;
                end
            end
            isa_pkg::CMD_REMOVE: begin
                if (IDX >= pos_w) begin
                    entry_next = right_val;
                end
                tag_hit_next = (IDX == pos_w);
                tag_val_next = entry_reg;
            end
            isa_pkg::CMD_WRITE: begin
                if (IDX == pos_w) begin
                    entry_next = cmd_val;
                end
            end
            isa_pkg::CMD_READ: begin
                tag_hit_next = (IDX == pos_w);
                tag_val_next = entry_reg;
            end
            isa_pkg::CMD_SEARCH: begin
                tag_hit_next = (entry_reg == cmd_val) && (IDX < cnt_w);
                tag_val_next = '0;
            end
            isa_pkg::CMD_SHIFT: begin
                tag_hit_next = tag_in_hit;
                tag_val_next = tag_in_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_hit_reg <= tag_hit_next;
        tag_val_reg <= tag_val_next;
    end

    assign entry_val = entry_reg;
    assign tag_hit   = tag_hit_reg;
    assign tag_val   = tag_val_reg;

endmodule

### rtl/isa_scan.sv
// Group scanner: walks the tag chain eight cells per cycle for the lowest hit.
module isa_scan #(
    parameter int ELEMENT_BITS = isa_pkg::DEFAULT_ELEMENT_BITS,
    parameter int CAPACITY     = isa_pkg::DEFAULT_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          start_srch,
    input  logic [isa_pkg::GROUP-1:0]     grp_hit,
    input  logic [ELEMENT_BITS-1:0]       grp_val [isa_pkg::GROUP],
    output isa_pkg::scan_res_t            res,
    output logic [ELEMENT_BITS-1:0]       res_val
);

    localparam int NG  = (CAPACITY + isa_pkg::GROUP - 1) / isa_pkg::GROUP;
    localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
    localparam int FW  = isa_pkg::FOUND_BITS;
    localparam int GW  = isa_pkg::GROUP_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic           state_reg, state_next;
    logic [GIW-1:0] gidx_reg, gidx_next;
    logic           srch_reg, srch_next;
    logic           any_hit, last_grp;
    logic [GW-1:0]  lo_idx;

    always_comb begin
        lo_idx = '0;
        for (int k = isa_pkg::GROUP - 1; k >= 0; k--) begin
            if (grp_hit[k]) begin
                lo_idx = GW'(k);
            end
        end
        any_hit  = |grp_hit;
        last_grp = (gidx_reg == GIW'(NG - 1));
    end

    always_comb begin
        state_next = state_reg;
        gidx_next  = gidx_reg;
        srch_next  = srch_reg;
        res        = '0;
        res.busy   = (state_reg == ST_SCAN);
        res.srch   = srch_reg;
        res.hit    = any_hit;
        res.found  = (srch_reg && any_hit) ? FW'({gidx_reg, lo_idx}) : '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SCAN;
                    gidx_next  = '0;
                    srch_next  = start_srch;
                end
            end
            ST_SCAN: begin
                if (any_hit || last_grp) begin
                    res.done   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    res.shift = 1'b1;
                    gidx_next = gidx_reg + GIW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gidx_reg  <= '0;
            srch_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            gidx_reg  <= gidx_next;
            srch_reg  <= srch_next;
        end
    end

    assign res_val = any_hit ? grp_val[lo_idx] : '0;

endmodule

### rtl/indexed_shift_array_top.sv
// Top level of the indexed shift array: handshake, count, cell row and scanner.
//
// An ordered array of CAPACITY elements held in a row of cells, one entry per
// cell. Insert and remove shift the cells from the position on by one place
// toward a neighbor; write updates the cell at the position. Insert, write and
// every rejected request give their result beat in the cycle after the input
// beat. Read, remove and search capture a tag in each cell and then shift the
// tags down the row eight cells per cycle, checking the lowest eight; a read
// or remove stops at the group that holds its position, a search at the first
// group with a hit or at the last group. One request is in flight at a time;
// the next beat is taken once the scan is done and the result register is
// free or being emptied.
module indexed_shift_array_top #(
    parameter int CAPACITY     = isa_pkg::DEFAULT_CAPACITY,
    parameter int ELEMENT_BITS = isa_pkg::DEFAULT_ELEMENT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], item_value[38:7], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_value[31:0], found_position[37:32],
                                   // status[39:38], element_count[46:40], zero pad
);

    localparam int CW    = $clog2(CAPACITY+1);
    localparam int CMPW  = (CW > isa_pkg::POS_BITS) ? CW : isa_pkg::POS_BITS;
    localparam int GRP   = isa_pkg::GROUP;
    localparam int NG    = (CAPACITY + GRP - 1) / GRP;
    localparam int NPAD  = NG * GRP;
    localparam int VW    = isa_pkg::VALUE_BITS;
    localparam int FW    = isa_pkg::FOUND_BITS;
    localparam int SW    = isa_pkg::STATUS_BITS;
    localparam int NW    = isa_pkg::COUNT_BITS;

    logic                          s_acc;
    logic [isa_pkg::KIND_BITS-1:0] in_kind;
    logic [isa_pkg::POS_BITS-1:0]  in_pos;
    logic [ELEMENT_BITS-1:0]       in_val;
    logic [CMPW-1:0]               pos_w, cnt_w;
    logic                          ins_ok, in_rng;

    logic [CW-1:0] count_reg, count_next;

    isa_pkg::cell_cmd_t  cmd;
    isa_pkg::scan_res_t  scan;
    logic [ELEMENT_BITS-1:0] scan_val;
    logic                    scan_start, scan_srch;
    logic                    imm_load;
    logic [SW-1:0]           imm_status;

    logic [ELEMENT_BITS-1:0] entry_w   [CAPACITY];
    logic                    tag_hit_w [NPAD];
    logic [ELEMENT_BITS-1:0] tag_val_w [NPAD];
    logic [GRP-1:0]          grp_hit;
    logic [ELEMENT_BITS-1:0] grp_val   [GRP];

    logic          m_tvalid_reg;
    logic [VW-1:0] res_value_reg;
    logic [FW-1:0] found_reg;
    logic [SW-1:0] status_reg;
    logic [NW-1:0] count_out_reg;

    assign in_kind  = s_tuser;
    assign in_pos   = s_tdata[6:0];
    assign in_val   = ELEMENT_BITS'(s_tdata[38:7]);
    assign s_tready = !scan.busy && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        pos_w      = CMPW'(in_pos);
        cnt_w      = CMPW'(count_reg);
        ins_ok     = (pos_w <= cnt_w) && (count_reg != CW'(CAPACITY));
        in_rng     = (pos_w < cnt_w);
        cmd.pos    = in_pos;
        cmd.code   = isa_pkg::CMD_IDLE;
        count_next = count_reg;
        scan_start = 1'b0;
        scan_srch  = 1'b0;
        imm_load   = 1'b0;
        imm_status = isa_pkg::STATUS_BAD;
        if (scan.shift) begin
            cmd.code = isa_pkg::CMD_SHIFT;
        end else if (s_acc) begin
            unique case (in_kind)
                isa_pkg::KIND_INSERT: begin
                    imm_load = 1'b1;
                    if (ins_ok) begin
                        cmd.code   = isa_pkg::CMD_INSERT;
                        count_next = count_reg + CW'(1);
                        imm_status = isa_pkg::STATUS_OK;
                    end
                end
                isa_pkg::KIND_REMOVE: begin
                    if (in_rng) begin
                        cmd.code   = isa_pkg::CMD_REMOVE;
                        count_next = count_reg - CW'(1);
                        scan_start = 1'b1;
                    end else begin
                        imm_load = 1'b1;
                    end
                end
                isa_pkg::KIND_READ: begin
                    if (in_rng) begin
                        cmd.code   = isa_pkg::CMD_READ;
                        scan_start = 1'b1;
                    end else begin
                        imm_load = 1'b1;
                    end
                end
                isa_pkg::KIND_WRITE: begin
                    imm_load = 1'b1;
                    if (in_rng) begin
                        cmd.code   = isa_pkg::CMD_WRITE;
                        imm_status = isa_pkg::STATUS_OK;
                    end
                end
                isa_pkg::KIND_SEARCH: begin
                    cmd.code   = isa_pkg::CMD_SEARCH;
                    scan_start = 1'b1;
                    scan_srch  = 1'b1;
                end
                default: begin
                    imm_load = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ELEMENT_BITS-1:0] left_v, right_v, tin_v;
        logic                    tin_h;
        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = entry_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_mid_r
            assign right_v = entry_w[i+1];
        end
        if (i + GRP < NPAD) begin : g_tin
            assign tin_h = tag_hit_w[i+GRP];
            assign tin_v = tag_val_w[i+GRP];
        end else begin : g_tin_zero
            assign tin_h = 1'b0;
            assign tin_v = '0;
        end
        isa_cell #(
            .ELEMENT_BITS (ELEMENT_BITS),
            .CAPACITY     (CAPACITY),
            .INDEX        (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .cmd_val    (in_val),
            .count      (count_reg),
            .left_val   (left_v),
            .right_val  (right_v),
            .tag_in_hit (tin_h),
            .tag_in_val (tin_v),
            .entry_val  (entry_w[i]),
            .tag_hit    (tag_hit_w[i]),
            .tag_val    (tag_val_w[i])
        );
    end

    for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
        assign tag_hit_w[i] = 1'b0;
        assign tag_val_w[i] = '0;
    end

    for (genvar k = 0; k < GRP; k++) begin : g_grp
        assign grp_hit[k] = tag_hit_w[k];
        assign grp_val[k] = tag_val_w[k];
    end

    isa_scan #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .CAPACITY     (CAPACITY)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .start_srch (scan_srch),
        .grp_hit    (grp_hit),
        .grp_val    (grp_val),
        .res        (scan),
        .res_val    (scan_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (imm_load || scan.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (imm_load) begin
            res_value_reg <= '0;
            found_reg     <= '0;
            status_reg    <= imm_status;
            count_out_reg <= NW'(count_next);
        end else if (scan.done) begin
            res_value_reg <= VW'(scan_val);
            found_reg     <= scan.found;
            status_reg    <= scan.hit ? isa_pkg::STATUS_OK : isa_pkg::STATUS_MISSING;
            count_out_reg <= NW'(count_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, count_out_reg, status_reg, found_reg, res_value_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_done_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        scan.done |-> !m_tvalid_reg)
        else $error("scan finished while result register still full");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        scan.busy |-> !s_tready)
        else $error("input beat taken during scan");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.code == isa_pkg::CMD_INSERT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance the count");

    a_single_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(imm_load && scan.done))
        else $error("two results loaded in one cycle");
`endif

endmodule

### verif/isa_checker.sv
// Result checker for the indexed shift array: models the array and compares every result beat.
module isa_checker
    import isa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          failures,
    output int          pending_beats
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = DEFAULT_CAPACITY;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic [FOUND_BITS-1:0]  found;
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  count;
    } array_result_t;

    logic [VALUE_BITS-1:0] slots [SLOTS];
    logic [COUNT_BITS-1:0] fill;
    array_result_t         awaited_results [$];
    array_result_t         got;
    array_result_t         want;
    array_result_t         fresh;

    function automatic array_result_t apply_request(input logic [KIND_BITS-1:0]  kind,
                                                    input logic [POS_BITS-1:0]   pos,
                                                    input logic [VALUE_BITS-1:0] val);
        array_result_t r;
        int            i;
        int            n;
        int            p;
        r        = '0;
        r.status = STATUS_OK;
        n        = int'(fill);
        p        = int'(pos);
        case (kind)
            KIND_INSERT: begin
                if (p > n || n >= SLOTS) begin
                    r.status = STATUS_BAD;
                end else begin
                    for (i = n; i > p; i--) slots[i] = slots[i-1];
                    slots[p] = val;
                    n        = n + 1;
                end
            end
            KIND_REMOVE: begin
                if (p >= n) begin
                    r.status = STATUS_BAD;
                end else begin
                    r.value = slots[p];
                    for (i = p; i + 1 < n; i++) slots[i] = slots[i+1];
                    slots[n-1] = '0;
                    n          = n - 1;
                end
            end
            KIND_READ: begin
                if (p >= n) r.status = STATUS_BAD;
                else r.value = slots[p];
            end
            KIND_WRITE: begin
                if (p >= n) r.status = STATUS_BAD;
                else slots[p] = val;
            end
            KIND_SEARCH: begin
                r.status = STATUS_MISSING;
                for (i = 0; i < n; i++) begin
                    if (r.status == STATUS_MISSING && slots[i] == val) begin
                        r.found  = FOUND_BITS'(i);
                        r.status = STATUS_OK;
                    end
                end
            end
            default: r.status = STATUS_BAD;
        endcase
        fill    = COUNT_BITS'(n);
        r.count = fill;
        return r;
    endfunction

    task automatic note_failure(input string what, input array_result_t exp_r,
                                input array_result_t act_r);
        if (failures < MAX_REPORT)
            $display("%t %s: expected value=%h found=%0d status=%0d count=%0d, ",
                     $realtime, what, exp_r.value, exp_r.found, exp_r.status, exp_r.count,
                     "got value=%h found=%0d status=%0d count=%0d",
                     act_r.value, act_r.found, act_r.status, act_r.count);
        failures++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) slots[i] = '0;
            fill = '0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata[31:0];
                got.found  = m_tdata[37:32];
                got.status = m_tdata[39:38];
                got.count  = m_tdata[46:40];
                if (awaited_results.size() == 0) begin
                    note_failure("unexpected result beat", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) note_failure("result beat differs", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = apply_request(s_tuser, s_tdata[6:0], s_tdata[38:7]);
                awaited_results.insert(awaited_results.size(), fresh);
            end
        end
        pending_beats <= awaited_results.size();
    end

endmodule

### verif/tb.sv
// Testbench top for the indexed shift array: clock, reset, request stimulus and verdict.
module tb;

    import isa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 600;
    localparam int SETTLE       = 30;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [KIND_BITS-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_C = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int failures;
    int pending_beats;
    int beats_sent  = 0;
    int burst_left  = 1;
    int shadow_fill = 0;
    int cycle_count = 0;

    logic [VALUE_BITS-1:0] value_pool [16];

    indexed_shift_array_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    isa_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .failures      (failures),
        .pending_beats (pending_beats)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("indexed_shift_array_top: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input logic [KIND_BITS-1:0] kind, input logic [POS_BITS-1:0] pos,
                             input logic [VALUE_BITS-1:0] value, input bit drain_after);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, value, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (kind == KIND_INSERT && pos <= shadow_fill && shadow_fill < SLOTS) shadow_fill++;
        if (kind == KIND_REMOVE && pos < shadow_fill) shadow_fill--;
        if (burst_left > 0) burst_left--;
        if (drain_after) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (pending_beats != 0) @(posedge aclk);
        end else if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    // receiver: random stall patterns plus one long hold-off to back up the input
    initial begin : receiver
        int  mode;
        int  mode_left;
        int  phase;
        bit  hold_done;
        mode_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        mode      = 0;
        forever begin
            @(posedge aclk);
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase % 5 != 4);
                endcase
            end
        end
    end

    initial begin : stimulus
        int                    n;
        int                    mode;
        int                    mode_left;
        int                    roll;
        int                    top_pos;
        logic [KIND_BITS-1:0]  kind;
        logic [POS_BITS-1:0]   pos;
        logic [VALUE_BITS-1:0] value;

        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < 16; i++) value_pool[i] = $urandom;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(KIND_SEARCH, 7'd0, 32'h0000_0000, 1'b0);
        send_beat(KIND_REMOVE, 7'd0, 32'h0000_0000, 1'b0);
        send_beat(KIND_READ,   7'd0, 32'h0000_0000, 1'b0);
        send_beat(KIND_WRITE,  7'd0, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_INSERT, 7'd1, 32'h0000_0001, 1'b0);
        send_beat(KIND_INSERT, 7'd0, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_INSERT, 7'd1, 32'h0000_0000, 1'b0);
        send_beat(KIND_INSERT, 7'd0, 32'h1234_5678, 1'b0);
        send_beat(KIND_INSERT, 7'd3, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_READ,   7'd3, 32'h0000_0000, 1'b0);
        send_beat(KIND_READ,   7'd4, 32'h0000_0000, 1'b0);
        send_beat(KIND_WRITE,  7'd1, 32'hA5A5_A5A5, 1'b0);
        send_beat(KIND_SEARCH, 7'd0, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_SEARCH, 7'd0, 32'h0000_0000, 1'b0);
        send_beat(KIND_SEARCH, 7'd0, 32'h5A5A_5A5A, 1'b0);
        send_beat(KIND_REMOVE, 7'd0, 32'h0000_0000, 1'b0);
        send_beat(KIND_REMOVE, 7'd2, 32'h0000_0000, 1'b0);
        send_beat(KIND_SPARE_A, 7'd127, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_SPARE_B, 7'd0,   32'h0000_0000, 1'b0);
        send_beat(KIND_SPARE_C, 7'd64,  32'h8000_0001, 1'b0);
        send_beat(KIND_INSERT, 7'd127, 32'h0000_0001, 1'b0);
        send_beat(KIND_REMOVE, 7'd127, 32'h0000_0000, 1'b0);
        send_beat(KIND_READ,   7'd1,   32'h0000_0000, 1'b1);

        mode      = MODE_FILL;
        mode_left = 160;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(MODE_FILL, MODE_MIX);
                mode_left = $urandom_range(30, 120);
            end
            mode_left--;
            roll = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:
                    kind = (roll < 60) ? KIND_INSERT : (roll < 65) ? KIND_REMOVE :
                           (roll < 75) ? KIND_READ   : (roll < 85) ? KIND_WRITE  :
                           (roll < 97) ? KIND_SEARCH : KIND_SPARE_A;
                MODE_DRAIN:
                    kind = (roll < 5)  ? KIND_INSERT : (roll < 65) ? KIND_REMOVE :
                           (roll < 75) ? KIND_READ   : (roll < 85) ? KIND_WRITE  :
                           (roll < 97) ? KIND_SEARCH : KIND_SPARE_B;
                default:
                    kind = (roll < 25) ? KIND_INSERT : (roll < 45) ? KIND_REMOVE :
                           (roll < 60) ? KIND_READ   : (roll < 75) ? KIND_WRITE  :
                           (roll < 97) ? KIND_SEARCH : KIND_SPARE_C;
            endcase
            top_pos = (kind == KIND_INSERT) ? shadow_fill
                                            : ((shadow_fill > 0) ? shadow_fill - 1 : 0);
            if ($urandom_range(0, 9) == 0) pos = POS_BITS'($urandom_range(0, 127));
            else pos = POS_BITS'($urandom_range(0, top_pos));
            value = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 15)] : $urandom;
            send_beat(kind, pos, value, n == DRAIN_AT);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (failures == 0 && pending_beats == 0) begin
            $display("indexed_shift_array_top: match");
        end else begin
            $display("indexed_shift_array_top: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/isa_pkg.sv
rtl/isa_cell.sv
rtl/isa_scan.sv
rtl/indexed_shift_array_top.sv
verif/isa_checker.sv
verif/tb.sv
